// ===== rtl/hsvf_pkg.sv =====
// Package for the harmonic SVF band-pass bank: sizes, opcodes, shared structs,
// saturation helper and the fixed shape weight tables. No dependencies.
package hsvf_pkg;

    localparam int HARM_COUNT    = 32;
    localparam int CASCADE       = 2;
    localparam int DEPTH         = CASCADE * HARM_COUNT;
    localparam int KW = (HARM_COUNT > 1) ? $clog2(HARM_COUNT) : 1;
    localparam int CW = (CASCADE > 1) ? $clog2(CASCADE) : 1;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int SHAPE_MAX = 742;

    // config register indexes
    localparam logic [1:0] REG_DAMPING   = 2'd0;
    localparam logic [1:0] REG_SHAPE_POS = 2'd1;
    localparam logic [1:0] REG_SHAPE_MOD = 2'd2;

    localparam logic [15:0] DAMPING_RST = 16'd677;

    typedef enum logic [4:0] {
        OP_NOP, OP_ACCEPT, OP_WGT, OP_RD, OP_LD, OP_M_S1GR, OP_DIFF, OP_M_HLO,
        OP_M_HHI, OP_HP, OP_M_HPG, OP_BP, OP_M_BPG, OP_S2, OP_M_BPD, OP_Y,
        OP_M_YENV, OP_T, OP_M_TW, OP_ACC, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t        op;
        logic [KW-1:0] k;
        logic [CW-1:0] c;
    } dp_cmd_t;

    typedef struct packed {
        logic in_load;   // item at the input is a coefficient load
        logic in_env0;   // item at the input has zero envelope
        logic w_zero;    // current harmonic weight is zero
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

    localparam logic [15:0] SQUARE_W [32] = '{
        16'd21627, 16'd0, 16'd7209, 16'd0, 16'd4325, 16'd0, 16'd3090, 16'd0,
        16'd2403,  16'd0, 16'd1966, 16'd0, 16'd1664, 16'd0, 16'd1442, 16'd0,
        16'd1272,  16'd0, 16'd1138, 16'd0, 16'd1030, 16'd0, 16'd940,  16'd0,
        16'd865,   16'd0, 16'd801,  16'd0, 16'd746,  16'd0, 16'd698,  16'd0
    };
    localparam logic [15:0] SAW_W [32] = '{
        16'd16384, 16'd8192, 16'd5461, 16'd4096, 16'd3277, 16'd2731, 16'd2341, 16'd2048,
        16'd1820,  16'd1638, 16'd1489, 16'd1365, 16'd1260, 16'd1170, 16'd1092, 16'd1024,
        16'd964,   16'd910,  16'd862,  16'd819,  16'd780,  16'd745,  16'd712,  16'd683,
        16'd655,   16'd630,  16'd607,  16'd585,  16'd565,  16'd546,  16'd529,  16'd512
    };
    localparam logic [15:0] TRI_W [32] = '{
        16'd18432, 16'd0, 16'd2048, 16'd0, 16'd737, 16'd0, 16'd376, 16'd0,
        16'd228,   16'd0, 16'd152,  16'd0, 16'd109, 16'd0, 16'd82,  16'd0,
        16'd64,    16'd0, 16'd51,   16'd0, 16'd42,  16'd0, 16'd35,  16'd0,
        16'd29,    16'd0, 16'd25,   16'd0, 16'd22,  16'd0, 16'd19,  16'd0
    };

    // shapes: 0 sine, 1 square, 2 saw, 3 triangle
    function automatic logic [15:0] shape_weight(input logic [1:0] sh, input logic [4:0] k);
        logic [15:0] w;
        case (sh)
            2'd0:    w = (k == 5'd0) ? 16'd32768 : 16'd0;
            2'd1:    w = SQUARE_W[k];
            2'd2:    w = SAW_W[k];
            default: w = TRI_W[k];
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/hsvf_datapath.sv =====
// Datapath of the SVF bank: config registers, coefficient tables, integrator
// memories, one shared multiplier and the output register. Uses hsvf_pkg.
module hsvf_datapath import hsvf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic              s_tuser,
    input  logic [103:0]      s_tdata,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata
);

    // input decode
    logic signed [15:0] smp_in, prior_in;
    logic [15:0]        env_in;
    logic [4:0]         harm_idx;
    logic [23:0]        coef_g, coef_h;
    assign smp_in    = s_tdata[15:0];
    assign prior_in  = s_tdata[31:16];
    assign env_in    = s_tdata[47:32];
    assign harm_idx  = s_tdata[52:48];
    assign coef_g    = s_tdata[76:53];
    assign coef_h    = s_tdata[100:77];

    logic [15:0]        damping_reg;
    logic [9:0]         shape_pos_reg;
    logic signed [10:0] shape_mod_reg;
    logic [23:0]        g_tab [HARM_COUNT];
    logic [23:0]        h_tab [HARM_COUNT];
    logic [DEPTH-1:0]   vld_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_data_reg;

    logic signed [31:0] mem1 [DEPTH];
    logic signed [31:0] mem2 [DEPTH];
    logic signed [31:0] rd1_reg, rd2_reg;
    logic               rdv_reg;

    logic signed [15:0] sample_reg, prior_reg;
    logic [15:0]        env_reg;
    logic [15:0]        w_reg;
    logic [23:0]        g_reg, h_reg;
    logic signed [31:0] x_reg, s1_reg, s2_reg, hp_reg, bp_reg, s1n_reg, t_reg;
    logic signed [41:0] diff_reg;
    logic signed [59:0] prod_reg, tmp_reg;
    logic signed [39:0] acc_reg;

    logic [AW-1:0] addr;
    assign addr = AW'(cmd.c) * AW'(HARM_COUNT) + AW'(cmd.k);

    logic in_range;
    assign in_range = {2'b00, harm_idx} < 7'(HARM_COUNT);

    // shape position and weight
    logic signed [11:0] pos_raw;
    logic [9:0]         pos_c;
    logic [15:0]        wl, wh;
    logic [25:0]        wsum;
    logic [15:0]        w_next;
    always_comb begin
        pos_raw = 12'(signed'({2'b00, shape_pos_reg})) + 12'(shape_mod_reg);
        if (pos_raw < 12'sd0) begin
            pos_c = 10'd0;
        end else if (pos_raw > 12'(SHAPE_MAX)) begin
            pos_c = 10'(SHAPE_MAX);
        end else begin
            pos_c = pos_raw[9:0];
        end
        wl = shape_weight(pos_c[9:8], 5'(cmd.k));
        wh = shape_weight(pos_c[9:8] + 2'd1, 5'(cmd.k));
        wsum = 26'(wl) * (26'd256 - 26'(pos_c[7:0])) + 26'(wh) * 26'(pos_c[7:0]);
        w_next = 16'((wsum + 26'd128) >> 8);
    end

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [59:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_M_S1GR: begin
                mul_a = 33'(s1_reg);
                mul_b = signed'(27'({1'b0, g_reg} + {1'b0, damping_reg, 8'd0}));
            end
            OP_M_HLO: begin
                mul_a = signed'({13'd0, diff_reg[19:0]});
                mul_b = signed'({3'd0, h_reg});
            end
            OP_M_HHI: begin
                mul_a = 33'(signed'(diff_reg[41:20]));
                mul_b = signed'({3'd0, h_reg});
            end
            OP_M_HPG: begin
                mul_a = 33'(hp_reg);
                mul_b = signed'({3'd0, g_reg});
            end
            OP_M_BPG: begin
                mul_a = 33'(bp_reg);
                mul_b = signed'({3'd0, g_reg});
            end
            OP_M_BPD: begin
                mul_a = 33'(bp_reg);
                mul_b = signed'({11'd0, damping_reg});
            end
            OP_M_YENV: begin
                mul_a = 33'(x_reg);
                mul_b = signed'({11'd0, env_reg});
            end
            OP_M_TW: begin
                mul_a = 33'(t_reg);
                mul_b = signed'({11'd0, w_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 60'(mul_a) * 60'(mul_b);
    end

    // post-processing
    logic signed [59:0] rnd20, rnd12, rnd16, rnd15;
    logic signed [65:0] hfull;
    logic signed [31:0] hp_next, bp_next, s1n_next, s2n_next, y_next;
    logic signed [39:0] out_v, out_r;
    logic [15:0]        out_next;
    always_comb begin
        rnd20 = (prod_reg + 60'sd524288) >>> 20;
        rnd12 = (prod_reg + 60'sd2048) >>> 12;
        rnd16 = (prod_reg + 60'sd32768) >>> 16;
        rnd15 = (prod_reg + 60'sd16384) >>> 15;
        hfull = (66'(prod_reg) <<< 20) + 66'(tmp_reg);
        hp_next  = sat32((hfull + 66'sd4194304) >>> 23);
        bp_next  = sat32(66'(rnd20) + 66'(s1_reg));
        s1n_next = sat32(66'(rnd20) + 66'(bp_next));
        s2n_next = sat32((66'(rnd20) <<< 1) + 66'(s2_reg));
        y_next   = sat32(66'(rnd12));
        out_v = (40'(prior_reg) <<< 7) + acc_reg;
        out_r = (out_v + 40'sd64) >>> 7;
        if (out_r > 40'sd32767) begin
            out_next = 16'h7fff;
        end else if (out_r < -40'sd32768) begin
            out_next = 16'h8000;
        end else begin
            out_next = out_r[15:0];
        end
    end

    // control state: config, tables, valid bits, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damping_reg   <= DAMPING_RST;
            shape_pos_reg <= '0;
            shape_mod_reg <= '0;
            vld_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < HARM_COUNT; i++) begin
                g_tab[i] <= '0;
                h_tab[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DAMPING:   damping_reg   <= cfg_data;
                    REG_SHAPE_POS: shape_pos_reg <= cfg_data[9:0];
                    REG_SHAPE_MOD: shape_mod_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_ACCEPT: begin
                    if (s_tuser) begin
                        if (in_range) begin
                            g_tab[harm_idx[KW-1:0]] <= coef_g;
                            h_tab[harm_idx[KW-1:0]] <= coef_h;
                        end
                    end else if (env_in == 16'd0) begin
                        vld_reg <= '0;
                    end
                end
                OP_S2:  vld_reg[addr] <= 1'b1;
                OP_OUT: m_tvalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // integrator memories
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_S2) begin
            mem1[addr] <= s1n_reg;
            mem2[addr] <= s2n_next;
        end
        rd1_reg <= mem1[addr];
        rd2_reg <= mem2[addr];
        rdv_reg <= vld_reg[addr];
    end

    // payload
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                sample_reg <= smp_in;
                prior_reg  <= prior_in;
                env_reg    <= env_in;
                acc_reg    <= '0;
            end
            OP_WGT: begin
                w_reg <= w_next;
                g_reg <= g_tab[cmd.k];
                h_reg <= h_tab[cmd.k];
                x_reg <= 32'(sample_reg) <<< 7;
            end
            OP_LD: begin
                s1_reg <= rdv_reg ? rd1_reg : 32'sd0;
                s2_reg <= rdv_reg ? rd2_reg : 32'sd0;
            end
            OP_M_S1GR, OP_M_HLO, OP_M_HPG, OP_M_BPG, OP_M_BPD, OP_M_YENV, OP_M_TW: begin
                prod_reg <= mul_p;
            end
            OP_M_HHI: begin
                tmp_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_DIFF: diff_reg <= 42'(x_reg) - 42'(rnd20) - 42'(s2_reg);
            OP_HP:   hp_reg <= hp_next;
            OP_BP: begin
                bp_reg  <= bp_next;
                s1n_reg <= s1n_next;
            end
            OP_Y:    x_reg <= y_next;
            OP_T:    t_reg <= rnd16[31:0];
            OP_ACC:  acc_reg <= acc_reg + 40'(rnd15);
            OP_OUT:  m_data_reg <= out_next;
            default: ;
        endcase
    end

    assign status.in_load  = s_tuser;
    assign status.in_env0  = (env_in == 16'd0);
    assign status.w_zero   = (w_reg == 16'd0);
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten while pending");
    a_write_weighted: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_S2) |-> (w_reg != 16'd0))
        else $error("integrator written for a skipped harmonic");
    a_env_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ACCEPT && !s_tuser && env_in == 16'd0) |=> (vld_reg == '0))
        else $error("integrators not cleared on zero envelope");

endmodule

// ===== rtl/hsvf_ctrl.sv =====
// Sequencer of the SVF bank: walks harmonics and cascade stages and issues one
// datapath operation per cycle when not stalled. Uses hsvf_pkg.
module hsvf_ctrl import hsvf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001, ST_WGT   = 20'h00002, ST_RD    = 20'h00004,
        ST_LD     = 20'h00008, ST_S1GR  = 20'h00010, ST_DIFF  = 20'h00020,
        ST_HLO    = 20'h00040, ST_HHI   = 20'h00080, ST_HP    = 20'h00100,
        ST_HPG    = 20'h00200, ST_BP    = 20'h00400, ST_BPG   = 20'h00800,
        ST_S2     = 20'h01000, ST_BPD   = 20'h02000, ST_Y     = 20'h04000,
        ST_YENV   = 20'h08000, ST_T     = 20'h10000, ST_TW    = 20'h20000,
        ST_ACC    = 20'h40000, ST_FIN   = 20'h80000
    } state_t;

    state_t        state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic [CW-1:0] c_reg, c_next;
    dp_op_t        op;
    logic          last_k;

    assign last_k = (k_reg == KW'(HARM_COUNT - 1));

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        op         = OP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op = OP_ACCEPT;
                    if (status.in_load) begin
                        state_next = ST_IDLE;
                    end else if (status.in_env0) begin
                        state_next = ST_FIN;
                    end else begin
                        k_next     = '0;
                        state_next = ST_WGT;
                    end
                end
            end
            ST_WGT: begin
                op         = OP_WGT;
                c_next     = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                op = OP_RD;
                if (status.w_zero) begin
                    if (last_k) begin
                        state_next = ST_FIN;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_WGT;
                    end
                end else begin
                    state_next = ST_LD;
                end
            end
            ST_LD:   begin op = OP_LD;     state_next = ST_S1GR; end
            ST_S1GR: begin op = OP_M_S1GR; state_next = ST_DIFF; end
            ST_DIFF: begin op = OP_DIFF;   state_next = ST_HLO;  end
            ST_HLO:  begin op = OP_M_HLO;  state_next = ST_HHI;  end
            ST_HHI:  begin op = OP_M_HHI;  state_next = ST_HP;   end
            ST_HP:   begin op = OP_HP;     state_next = ST_HPG;  end
            ST_HPG:  begin op = OP_M_HPG;  state_next = ST_BP;   end
            ST_BP:   begin op = OP_BP;     state_next = ST_BPG;  end
            ST_BPG:  begin op = OP_M_BPG;  state_next = ST_S2;   end
            ST_S2:   begin op = OP_S2;     state_next = ST_BPD;  end
            ST_BPD:  begin op = OP_M_BPD;  state_next = ST_Y;    end
            ST_Y: begin
                op = OP_Y;
                if (c_reg == CW'(CASCADE - 1)) begin
                    state_next = ST_YENV;
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_YENV: begin op = OP_M_YENV; state_next = ST_T;   end
            ST_T:    begin op = OP_T;      state_next = ST_TW;  end
            ST_TW:   begin op = OP_M_TW;   state_next = ST_ACC; end
            ST_ACC: begin
                op = OP_ACC;
                if (last_k) begin
                    state_next = ST_FIN;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_WGT;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            c_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.op   = op;
    assign cmd.k    = k_reg;
    assign cmd.c    = c_reg;

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && last_k) |=> (state_reg == ST_FIN))
        else $error("harmonic walk ran past the last harmonic");
    a_stage_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_YENV) |-> (c_reg == CW'(CASCADE - 1)))
        else $error("cascade left before its last stage");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_OUT) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return after a result");

endmodule

// ===== rtl/harmonic_svf_bandpass_bank.sv =====
// Top level of the harmonic SVF band-pass bank: stream ports, config port,
// sequencer and datapath. Uses hsvf_pkg, hsvf_ctrl, hsvf_datapath.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tuser cmd, s_tdata sample fields
//  m_       | out       | m_tvalid/m_tready  | m_tdata mixed_out
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load transaction and a sample with zero envelope take no filter steps.
// A sample walks all 32 harmonics, skips those whose weight is zero and runs
// the 2 cascade stages of the others; its time is set by the stage sequence
// through the single shared 33x27 multiplier.
// aresetn is synchronous, active low; it resets integrators, tables and config.
// A new transaction is taken while a result waits in the output register; the
// sequencer holds before writing the next result until that one is taken.
module harmonic_svf_bandpass_bank import hsvf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] cmd
    input  logic         s_tuser,
    // [15:0] audio sample, [31:16] prior_out, [47:32] env_level, [52:48] harm_index,
    // [76:53] coef_g, [100:77] coef_h, [103:101] zero
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] mixed_out
    output logic [15:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // config writes are taken in any cycle
    assign cfg_ready = 1'b1;

    hsvf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hsvf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sim/hsvf_scoreboard.sv =====
// Checker for the harmonic SVF band-pass bank: watches the sample, result and
// config channels, models the filter bank and compares results. Uses hsvf_pkg.
module hsvf_scoreboard import hsvf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         s_tuser,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;

    longint s1_mem [CASCADE][HARM_COUNT];
    longint s2_mem [CASCADE][HARM_COUNT];
    longint g_mem [HARM_COUNT];
    longint h_mem [HARM_COUNT];
    longint damp_q, spos_q, smod_q;
    logic [15:0] mix_q [$];

    function automatic longint rshr(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip32(longint v);
        if (v > I32MAX) return I32MAX;
        if (v < I32MIN) return I32MIN;
        return v;
    endfunction

    function automatic longint wtab(int sh, int k);
        int n;
        n = k + 1;
        case (sh)
            0: return (n == 1) ? 32768 : 0;
            1: return (n % 2) ? (2 * 21627 + n) / (2 * n) : 0;
            2: return (2 * 16384 + n) / (2 * n);
            default: return (n % 2) ? (2 * 18432 + n * n) / (2 * n * n) : 0;
        endcase
    endfunction

    function automatic longint svf_stage(longint x, int c, int k);
        longint g, h, gr, s1, s2, hp, a, bp, b;
        g = g_mem[k];
        h = h_mem[k];
        gr = g + damp_q * 256;
        s1 = s1_mem[c][k];
        s2 = s2_mem[c][k];
        hp = clip32(rshr(h * (x - rshr(s1 * gr, 20) - s2), 23));
        a = rshr(hp * g, 20);
        bp = clip32(a + s1);
        s1_mem[c][k] = clip32(a + bp);
        b = rshr(bp * g, 20);
        s2_mem[c][k] = clip32(b + b + s2);
        return clip32(rshr(bp * damp_q, 12));
    endfunction

    function automatic void apply_item(logic cmd, logic [103:0] d);
        longint x, prior, env, acc, pos, f, w, y, r;
        int lo;
        x = longint'($signed(d[15:0])) * 128;
        prior = longint'($signed(d[31:16]));
        env = longint'(d[47:32]);
        acc = 0;
        if (cmd) begin
            g_mem[d[52:48]] = d[76:53];
            h_mem[d[52:48]] = d[100:77];
            return;
        end
        if (env == 0) begin
            foreach (s1_mem[c, k]) begin
                s1_mem[c][k] = 0;
                s2_mem[c][k] = 0;
            end
            mix_q.push_back(d[31:16]);
            return;
        end
        pos = spos_q + smod_q;
        if (pos < 0) pos = 0;
        if (pos > SHAPE_MAX) pos = SHAPE_MAX;
        lo = int'(pos >>> 8);
        f = pos & 255;
        for (int k = 0; k < HARM_COUNT; k++) begin
            w = rshr(wtab(lo, k) * (256 - f) + wtab(lo + 1, k) * f, 8);
            if (w != 0) begin
                y = x;
                for (int c = 0; c < CASCADE; c++) y = svf_stage(y, c, k);
                acc += rshr(rshr(y * env, 16) * w, 15);
            end
        end
        r = rshr(prior * 128 + acc, 7);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        mix_q.push_back(r[15:0]);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (s1_mem[c, k]) begin
                s1_mem[c][k] = 0;
                s2_mem[c][k] = 0;
            end
            foreach (g_mem[k]) begin
                g_mem[k] = 0;
                h_mem[k] = 0;
            end
            damp_q = 677;
            spos_q = 0;
            smod_q = 0;
            mix_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (mix_q.size() == 0) begin
                    $error("unexpected result mixed_out=%0d", $signed(m_tdata));
                    fail_count++;
                end else begin
                    if (m_tdata !== mix_q[0]) begin
                        $error("mixed_out expected %0d actual %0d",
                               $signed(mix_q[0]), $signed(m_tdata));
                        fail_count++;
                    end
                    void'(mix_q.pop_front());
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DAMPING:   damp_q = cfg_data;
                    REG_SHAPE_POS: spos_q = cfg_data[9:0];
                    REG_SHAPE_MOD: smod_q = longint'($signed(cfg_data[10:0]));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata);
        end
        pending = mix_q.size();
    end
endmodule

// ===== sim/tb_harmonic_svf_bandpass_bank.sv =====
// Testbench top for the harmonic SVF band-pass bank: clock, reset, stimulus
// and verdict. Uses hsvf_pkg, harmonic_svf_bandpass_bank, hsvf_scoreboard.
module tb_harmonic_svf_bandpass_bank;
    import hsvf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic         s_tuser = 1'b0;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;
    int           fail_count;
    int           pending;
    bit           stall_on = 1'b1;
    int           stall_left = 0;

    always #4 aclk = ~aclk;

    harmonic_svf_bandpass_bank u_dut (.*);

    hsvf_scoreboard u_chk (.*);

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver back-pressure: stalls of random length, a few of them long
    always @(posedge aclk) begin
        if (!aresetn || !stall_on) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= gap_len();
        end else begin
            m_tready   <= 1'b1;
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    // one sample/load transaction; gap before it on the sender side,
    // tvalid stays up after the handshake unless a gap or a pause follows
    task automatic send_item(logic cmd, logic signed [15:0] smp, logic signed [15:0] prior,
                             logic [15:0] env, logic [4:0] idx, logic [23:0] g,
                             logic [23:0] h);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            idle_cycles(n);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b0, h, g, idx, env, prior, smp};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_load(logic [4:0] idx, logic [23:0] g, logic [23:0] h);
        send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), idx, g, h);
    endtask

    task automatic send_sample(logic signed [15:0] smp, logic signed [15:0] prior,
                               logic [15:0] env);
        send_item(1'b0, smp, prior, env, 5'($urandom), 24'($urandom), 24'($urandom));
    endtask

    // sender stops, then waits until every expected result has come
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // block is idle once nothing is pending and the worst-case latency has passed
    task automatic drain();
        wait_results();
        idle_cycles(1100);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_regs(logic [15:0] damp, logic [9:0] pos, logic signed [10:0] smod);
        drain();
        write_reg(REG_DAMPING, damp);
        write_reg(REG_SHAPE_POS, 16'(pos));
        write_reg(REG_SHAPE_MOD, 16'(smod));
        cfg_valid <= 1'b0;
    endtask

    // realistic coefficient pair: small g, h normalized near one
    task automatic load_random_coef(logic [4:0] idx);
        logic [23:0] g;
        g = 24'($urandom_range(1000, 600000));
        send_load(idx, g, 24'($urandom_range(4000000, 8388608)));
    endtask

    task automatic random_sample();
        logic [15:0] env;
        int r;
        r = $urandom_range(0, 19);
        env = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom);
        send_sample(16'($urandom), 16'($urandom), env);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, zero envelope, zero tables, odd loads
        send_sample(16'sh7fff, 16'sh7fff, 16'hffff);
        send_sample(-16'sh8000, -16'sh8000, 16'hffff);
        send_sample(16'sh1234, 16'sh0100, 16'd0);
        send_load(5'd0, 24'hffffff, 24'h800000);
        send_load(5'd31, 24'd0, 24'd0);
        send_load(5'd1, 24'd300000, 24'h7fffff);
        send_load(5'd2, 24'd50000, 24'd8000000);
        send_sample(16'sh7fff, 16'sh7fff, 16'hffff);
        send_sample(-16'sh8000, -16'sh8000, 16'hffff);
        send_sample(16'sh4000, 16'sh0000, 16'd1);
        send_sample(16'sh0000, 16'sh0000, 16'd0);
        send_load(5'd0, 24'd120000, 24'd7000000);

        // extreme register settings
        set_regs(16'd205, 10'd0, -11'sd742);
        for (int k = 0; k < HARM_COUNT; k++) load_random_coef(5'(k));
        send_sample(16'sh7fff, 16'sh0000, 16'hffff);
        send_sample(-16'sh8000, 16'sh7fff, 16'hffff);
        set_regs(16'd40960, 10'd742, 11'sd742);
        send_sample(16'sh7fff, -16'sh8000, 16'hffff);
        send_sample(16'sh2000, 16'sh0000, 16'h8000);
        set_regs(16'hffff, 10'h3ff, 11'h400);
        send_sample(16'sh7fff, 16'sh7fff, 16'hffff);
        send_sample(-16'sh8000, -16'sh8000, 16'hffff);

        // random phases with new settings; loads and samples mixed
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 4) stall_on = 1'b0;
            if (ph == 5) stall_on = 1'b1;
            set_regs(16'($urandom_range(205, 40960)), 10'($urandom_range(0, 742)),
                     11'($signed($urandom_range(0, 1484)) - 742));
            for (int i = 0; i < 130; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_load(5'($urandom), 24'($urandom), 24'($urandom));
                    end else begin
                        load_random_coef(5'($urandom));
                    end
                end else begin
                    random_sample();
                end
                if (i == 60) begin
                    wait_results();
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("harmonic_svf_bandpass_bank regression: pass");
        end else begin
            $display("harmonic_svf_bandpass_bank regression: fail");
        end
        $finish;
    end

    // watchdog: ~1100 items at worst-case sample time plus stalls and gaps, several times over
    initial begin
        #60ms;
        $display("harmonic_svf_bandpass_bank regression: fail");
        $finish;
    end
endmodule

// ===== harmonic_svf_bandpass_bank.f =====
rtl/hsvf_pkg.sv
rtl/hsvf_datapath.sv
rtl/hsvf_ctrl.sv
rtl/harmonic_svf_bandpass_bank.sv
sim/hsvf_scoreboard.sv
sim/tb_harmonic_svf_bandpass_bank.sv
